// ===== design/sle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, constants and helpers of the stack language executor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DW         = 32;
  localparam int DEPTH      = 256;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int IW         = $clog2(DEPTH);
  localparam int CMPW       = (DW > CW) ? DW : CW;
  localparam int DIV_CNT_W  = $clog2(DW + 1);
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  typedef logic [DW-1:0] word_t;

  typedef enum logic [2:0] {
    OP_E = 3'd0, OP_T = 3'd1, OP_A = 3'd2, OP_O = 3'd3,
    OP_I = 3'd4, OP_N = 3'd5, OP_S = 3'd6, OP_H = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_BRANCH = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_UNDER = 3'd1,
    ERR_ROLL  = 3'd2,
    ERR_ASCII = 3'd3,
    ERR_LIT   = 3'd4,
    ERR_DIV0  = 3'd5,
    ERR_FULL  = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    CM_HOLD, CM_PUSH, CM_POP, CM_POP2, CM_POP_WRITE, CM_WRITE2, CM_SWAP
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t    mode;
    logic [IW-1:0] k;
    word_t         d0;
    word_t         d1;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DIV, S_ROLL, S_DUPPUSH, S_UNROLL, S_DONE
  } state_t;

  function automatic word_t word_mag(word_t v);
    return v[DW-1] ? (~v + word_t'(1)) : v;
  endfunction

  function automatic logic [31:0] jump_of(word_t v);
    logic signed [63:0] t;
    t = 64'(signed'(v));
    return t[31:0];
  endfunction

endpackage

// ===== design/sle_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell
// One stack word; takes its next value from itself, a nearby cell or the control data.
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [IW-1:0] idx,
  input  word_t         above,
  input  word_t         below,
  input  word_t         below2,
  output word_t         q
);

  word_t val_r, val_nxt;
  logic  is_top, is_k, is_km1;

  assign is_top = (idx == '0);
  assign is_k   = (idx == ctrl.k);
  assign is_km1 = ((IW + 1)'(idx) + (IW + 1)'(1) == (IW + 1)'(ctrl.k));

  always_comb begin
    val_nxt = val_r;
    case (ctrl.mode)
      CM_PUSH:      val_nxt = is_top ? ctrl.d0 : above;
      CM_POP:       val_nxt = below;
      CM_POP2:      val_nxt = below2;
      CM_POP_WRITE: val_nxt = is_top ? ctrl.d0 : below;
      CM_WRITE2: begin
        if (is_top) val_nxt = ctrl.d0;
        else if (idx == IW'(1)) val_nxt = ctrl.d1;
      end
      CM_SWAP: begin
        if (is_k) val_nxt = above;
        else if (is_km1) val_nxt = below;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

// ===== design/sle_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sle_div import sle_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t quo,
  output word_t rem
);

  logic [DW:0]        rem_r, rem_nxt;
  word_t              quo_r, quo_nxt, dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]        shifted, diff;

  assign shifted = {rem_r[DW-1:0], quo_r[DW-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dsr_r <= divisor;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r[DW-1:0];

endmodule

// ===== design/stack_language_executor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_language_executor
// Single-step executor of an eta-style stack language on a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Send one instruction per item on the in_ channel; one result item comes
//   back on the out_ channel for each instruction, in order.
//   The stack is a row of word cells with the top in cell 0; push, pop and
//   swap move words between neighboring cells, so deep accesses walk the row.
// Steps per item:
//   simple instructions are accepted, executed and handed to the output reg;
//   divide runs on the one-bit-per-cycle divider before the write-back;
//   roll by n and duplicate of depth n walk the element along the cells
//   by adjacent swaps, so their run grows with n.
//   One item is in work at a time; the next is accepted once it finishes.
// Reset: rst_n (synchronous, active low) empties the stack, clears literal
//   mode, the accumulator and the halt flag. Stack words are not cleared.
// Stall: a finished result waits in the output register while out_tready
//   is low; the next item may already be accepted and executed, and then
//   holds in the done state until the output register frees.
// After an error is reported every later item returns an all-zero result.
// ----------------------------------------------------------------------------
module stack_language_executor import sle_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // opcode[2:0], line_number[18:3], input_char[27:19]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_char[6:0], jump_target[38:7],
                                             // used_input[39], error_code[42:40]
  output logic [1:0]             out_tuser   // kind[1:0]
);

  // Result of one instruction
  typedef struct packed {
    kind_t       kind;
    logic [6:0]  ochar;
    logic [31:0] jump;
    logic        used;
    err_t        err;
  } res_t;

  state_t        state_r, state_nxt;
  opcode_t       op_r;
  logic [15:0]   line_r;
  logic [8:0]    ich_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          lit_r, lit_nxt, halted_r, halted_nxt;
  word_t         acc_r, acc_nxt;
  logic [IW-1:0] k_r, k_nxt, n_r, n_nxt;
  logic          dup_r, dup_nxt;
  res_t          res_r, res_nxt, out_r;
  logic          out_valid_r, out_valid_nxt;

  cell_ctrl_t    ctrl;
  word_t         stk [DEPTH];
  logic          div_start, div_done;
  word_t         div_quo, div_rem;

  // Row of stack cells, top of stack in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t above_w, below_w, below2_w;
    if (i == 0) begin : g_a0
      assign above_w = '0;
    end else begin : g_a
      assign above_w = stk[i-1];
    end
    if (i + 1 < DEPTH) begin : g_b
      assign below_w = stk[i+1];
    end else begin : g_b0
      assign below_w = '0;
    end
    if (i + 2 < DEPTH) begin : g_c
      assign below2_w = stk[i+2];
    end else begin : g_c0
      assign below2_w = '0;
    end
    sle_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .idx    (IW'(i)),
      .above  (above_w),
      .below  (below_w),
      .below2 (below2_w),
      .q      (stk[i])
    );
  end

  sle_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (word_mag(stk[1])),
    .divisor  (word_mag(stk[0])),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign in_tready = (state_r == S_IDLE);

  // Combinational helpers for the execute step
  logic          full, under1, under2;
  logic [CW-1:0] depth_w;
  word_t         mag0;
  logic [DW+2:0] lit_t;
  word_t         digit;
  word_t         q_s, r_s;

  assign full    = (cnt_r == CW'(DEPTH));
  assign under1  = (cnt_r == '0);
  assign under2  = (cnt_r < CW'(2));
  assign depth_w = cnt_r - CW'(1);
  assign mag0    = word_mag(stk[0]);
  assign digit   = (op_r == OP_H) ? '0 : word_t'(op_r);
  assign lit_t   = {acc_r, 3'b000} - {3'b000, acc_r} + {3'b000, digit};
  assign q_s     = (stk[1][DW-1] != stk[0][DW-1]) ? (~div_quo + word_t'(1)) : div_quo;
  assign r_s     = stk[1][DW-1] ? (~div_rem + word_t'(1)) : div_rem;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lit_nxt       = lit_r;
    acc_nxt       = acc_r;
    halted_nxt    = halted_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    dup_nxt       = dup_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    ctrl          = '{mode: CM_HOLD, k: k_r, d0: '0, d1: '0};
    div_start     = 1'b0;

    // Drop the output item once taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end

      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        if (halted_r) begin
          // hold: all-zero result
        end else if (lit_r) begin
          if (op_r == OP_E) begin
            if (acc_r[DW-1]) res_nxt.err = ERR_LIT;
            else if (full) res_nxt.err = ERR_FULL;
            else begin
              ctrl.mode = CM_PUSH;
              ctrl.d0   = acc_r;
              cnt_nxt   = cnt_r + CW'(1);
              lit_nxt   = 1'b0;
            end
          end else if (!acc_r[DW-1]) begin
            // Saturate to the sign word when the next digit overflows
            if (lit_t > (DW + 3)'({1'b0, {(DW - 1){1'b1}}})) acc_nxt = {1'b1, {(DW - 1){1'b0}}};
            else acc_nxt = lit_t[DW-1:0];
          end
        end else begin
          case (op_r)
            OP_E: begin
              if (under2) res_nxt.err = ERR_UNDER;
              else if (stk[0] == '0) res_nxt.err = ERR_DIV0;
              else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            OP_T: begin
              if (under2) res_nxt.err = ERR_UNDER;
              else begin
                ctrl.mode = CM_POP2;
                cnt_nxt   = cnt_r - CW'(2);
                if (stk[1] != '0) begin
                  res_nxt.kind = KIND_BRANCH;
                  res_nxt.jump = jump_of(stk[0]);
                end
              end
            end
            OP_A: begin
              if (full) res_nxt.err = ERR_FULL;
              else begin
                ctrl.mode = CM_PUSH;
                ctrl.d0   = word_t'({1'b0, line_r} + 17'd1);
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            OP_O: begin
              if (under1) res_nxt.err = ERR_UNDER;
              else if (stk[0] > word_t'(127)) res_nxt.err = ERR_ASCII;
              else begin
                ctrl.mode     = CM_POP;
                cnt_nxt       = cnt_r - CW'(1);
                res_nxt.kind  = KIND_CHAR;
                res_nxt.ochar = stk[0][6:0];
              end
            end
            OP_I: begin
              if (full) res_nxt.err = ERR_FULL;
              else begin
                ctrl.mode    = CM_PUSH;
                ctrl.d0      = word_t'(DW'(signed'(ich_r)));
                cnt_nxt      = cnt_r + CW'(1);
                res_nxt.used = 1'b1;
              end
            end
            OP_N: begin
              lit_nxt = 1'b1;
              acc_nxt = '0;
            end
            OP_S: begin
              if (under2) res_nxt.err = ERR_UNDER;
              else begin
                ctrl.mode = CM_POP_WRITE;
                ctrl.d0   = stk[1] - stk[0];
                cnt_nxt   = cnt_r - CW'(1);
              end
            end
            OP_H: begin
              if (under1) res_nxt.err = ERR_UNDER;
              else if (CMPW'(mag0) >= CMPW'(depth_w)) res_nxt.err = ERR_ROLL;
              else begin
                // Pop the index, then walk the chosen element to the top; a duplicate also pushes a copy
                ctrl.mode = CM_POP;
                cnt_nxt   = depth_w;
                dup_nxt   = (stk[0] == '0) || stk[0][DW-1];
                n_nxt     = mag0[IW-1:0];
                k_nxt     = mag0[IW-1:0];
                if (mag0 == '0) state_nxt = S_DUPPUSH;
                else state_nxt = S_ROLL;
              end
            end
            default: ;
          endcase
        end
        if (res_nxt.err != ERR_NONE) begin
          halted_nxt = 1'b1;
          ctrl.mode  = CM_HOLD;
          div_start  = 1'b0;
          cnt_nxt    = cnt_r;
          lit_nxt    = lit_r;
          acc_nxt    = acc_r;
          state_nxt  = S_DONE;
        end
      end

      S_DIV: begin
        if (div_done) begin
          ctrl.mode = CM_WRITE2;
          ctrl.d0   = r_s;
          ctrl.d1   = q_s;
          state_nxt = S_DONE;
        end
      end

      S_ROLL: begin
        ctrl.mode = CM_SWAP;
        k_nxt     = k_r - IW'(1);
        if (k_r == IW'(1)) state_nxt = dup_r ? S_DUPPUSH : S_DONE;
      end

      S_DUPPUSH: begin
        ctrl.mode = CM_PUSH;
        ctrl.d0   = stk[0];
        cnt_nxt   = cnt_r + CW'(1);
        k_nxt     = IW'(2);
        state_nxt = (n_r == '0) ? S_DONE : S_UNROLL;
      end

      S_UNROLL: begin
        // Walk the original back down below its copy
        ctrl.mode = CM_SWAP;
        k_nxt     = k_r + IW'(1);
        if (k_r == n_r + IW'(1)) state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lit_r       <= 1'b0;
      acc_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lit_r       <= lit_nxt;
      acc_r       <= acc_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r   <= k_nxt;
    n_r   <= n_nxt;
    dup_r <= dup_nxt;
    res_r <= res_nxt;
    if (state_r == S_IDLE && in_tvalid) begin
      op_r   <= opcode_t'(in_tdata[2:0]);
      line_r <= in_tdata[18:3];
      ich_r  <= in_tdata[27:19];
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) out_r <= res_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {5'b0, out_r.err, out_r.used, out_r.jump, out_r.ochar};

endmodule

// ===== sim/stack_language_executor_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_language_executor_checker
// Watches both streams of the executor, predicts every result item from the
// accepted instruction items and compares them field by field, in order.
// ----------------------------------------------------------------------------
module stack_language_executor_checker import sle_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // opcode[2:0], line_number[18:3], input_char[27:19]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // out_char[6:0], jump_target[38:7],
                                             // used_input[39], error_code[42:40]
  input  logic [1:0]             out_tuser,  // kind[1:0]
  output int                     fails,
  output int                     pending
);

  typedef struct {
    kind_t       kind;
    logic [6:0]  ch;
    logic [31:0] jump;
    logic        used;
    err_t        err;
  } step_result_t;

  step_result_t results_due[$];

  // Predicted machine state; the stack bottom sits at index 0.
  word_t       stk [DEPTH];
  int unsigned cnt = 0;
  bit          lit_on = 1'b0;
  word_t       acc = '0;
  bit          halted = 1'b0;

  initial begin
    fails   = 0;
    pending = 0;
  end

  function automatic word_t magnitude(word_t v);
    return v[DW-1] ? (word_t'(0) - v) : v;
  endfunction

  function automatic void push_word(word_t v);
    stk[cnt] = v;
    cnt++;
  endfunction

  function automatic step_result_t execute(opcode_t op, logic [15:0] line, logic [8:0] ich);
    step_result_t res;
    err_t         e;
    word_t        a, b, ma, mb, q, r, v, n, d;
    logic [63:0]  lim;
    int unsigned  depth, idx;
    res = '{KIND_NONE, 7'd0, 32'd0, 1'b0, ERR_NONE};
    e   = ERR_NONE;
    if (halted) return res;
    if (lit_on) begin
      if (op == OP_E) begin
        if (acc[DW-1]) e = ERR_LIT;
        else if (cnt >= DEPTH) e = ERR_FULL;
        else begin
          push_word(acc);
          lit_on = 1'b0;
        end
      end else begin
        // digit H stands for zero, the others for their own code
        d = (op == OP_H) ? word_t'(0) : word_t'(op);
        if (!acc[DW-1]) begin
          lim = (64'h7fff_ffff - 64'(d)) / 7;
          if (64'(acc) > lim) acc = word_t'(32'h8000_0000);
          else acc = acc * 7 + d;
        end
      end
    end else begin
      case (op)
        OP_E: begin
          if (cnt < 2) e = ERR_UNDER;
          else begin
            b = stk[cnt-1];
            a = stk[cnt-2];
            if (b == 0) e = ERR_DIV0;
            else begin
              ma = magnitude(a);
              mb = magnitude(b);
              q  = ma / mb;
              r  = ma % mb;
              if (a[DW-1] != b[DW-1]) q = word_t'(0) - q;
              if (a[DW-1]) r = word_t'(0) - r;
              cnt -= 2;
              push_word(q);
              push_word(r);
            end
          end
        end
        OP_T: begin
          if (cnt < 2) e = ERR_UNDER;
          else begin
            b = stk[cnt-1];
            a = stk[cnt-2];
            cnt -= 2;
            if (a != 0) begin
              res.kind = KIND_BRANCH;
              res.jump = b[31:0];
            end
          end
        end
        OP_A: begin
          if (cnt >= DEPTH) e = ERR_FULL;
          else push_word(word_t'(line) + 1);
        end
        OP_O: begin
          if (cnt < 1) e = ERR_UNDER;
          else if (stk[cnt-1] > 127) e = ERR_ASCII;
          else begin
            cnt--;
            res.kind = KIND_CHAR;
            res.ch   = stk[cnt][6:0];
          end
        end
        OP_I: begin
          if (cnt >= DEPTH) e = ERR_FULL;
          else begin
            push_word({{(DW-9){ich[8]}}, ich});
            res.used = 1'b1;
          end
        end
        OP_N: begin
          lit_on = 1'b1;
          acc    = '0;
        end
        OP_S: begin
          if (cnt < 2) e = ERR_UNDER;
          else begin
            b = stk[cnt-1];
            a = stk[cnt-2];
            cnt -= 2;
            push_word(a - b);
          end
        end
        default: begin
          // roll for a positive index, duplicate for zero or negative
          if (cnt < 1) e = ERR_UNDER;
          else begin
            b     = stk[cnt-1];
            depth = cnt - 1;
            n     = magnitude(b);
            if (n >= depth) e = ERR_ROLL;
            else begin
              cnt--;
              idx = depth - 1 - n;
              v   = stk[idx];
              if (b == 0 || b[DW-1]) push_word(v);
              else begin
                for (int k = idx; k < depth - 1; k++) stk[k] = stk[k+1];
                stk[depth-1] = v;
              end
            end
          end
        end
      endcase
    end
    if (e != ERR_NONE) begin
      res     = '{KIND_NONE, 7'd0, 32'd0, 1'b0, e};
      halted  = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    step_result_t want, seen;
    if (rst_n && in_tvalid && in_tready)
      results_due.push_back(execute(opcode_t'(in_tdata[2:0]), in_tdata[18:3], in_tdata[27:19]));
    if (rst_n && out_tvalid && out_tready) begin
      seen = '{kind_t'(out_tuser), out_tdata[6:0], out_tdata[38:7], out_tdata[39],
               err_t'(out_tdata[42:40])};
      if (results_due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result item with nothing pending: kind %0d err %0d", $realtime,
                   seen.kind, seen.err);
      end else begin
        want = results_due.pop_front();
        if (seen.kind != want.kind || seen.ch != want.ch || seen.jump != want.jump ||
            seen.used != want.used || seen.err != want.err) begin
          fails++;
          if (fails <= 10)
            $display("%0t: mismatch kind/char/jump/used/err exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     $realtime, want.kind, want.ch, $signed(want.jump), want.used, want.err,
                     seen.kind, seen.ch, $signed(seen.jump), seen.used, seen.err);
        end
      end
    end
    pending = results_due.size();
  end

endmodule

// ===== sim/stack_language_executor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_language_executor_tb
// Feeds instruction programs to the executor and judges its results.
// A directed opening hits field extremes and arithmetic corner cases, then
// random well-formed instruction groups run with a shadow of the stack depth
// so no error fires early; one deep fill exercises the full stack, and the run
// closes with one randomly chosen error followed by items after the halt.
// ----------------------------------------------------------------------------
module stack_language_executor_tb;
  import sle_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // opcode[2:0], line_number[18:3], input_char[27:19]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // out_char[6:0], jump_target[38:7],
                                      // used_input[39], error_code[42:40]
  logic [1:0]             out_tuser;  // kind[1:0]
  int                     fails;
  int                     pending;
  int                     cyc = 0;
  int                     nitems = 0;
  int                     sd = 0;     // stack depth the program has built so far

  always #5 clk = ~clk;
  always @(posedge clk) cyc <= cyc + 1;

  stack_language_executor dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  stack_language_executor_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fails(fails), .pending(pending)
  );

  // Both sides drop idling in this window.
  function automatic bit quiet();
    return cyc >= 1500 && cyc < 2500;
  endfunction

  // Offer one item after a random gap and hold it until accepted.
  task automatic issue_at(opcode_t op, logic [15:0] line, logic [8:0] ich);
    while (!quiet() && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, ich, line, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    nitems++;
  endtask

  task automatic issue(opcode_t op, logic [8:0] ich);
    issue_at(op, 16'($urandom_range(0, 65535)), ich);
  endtask

  // Open a literal, send its base-7 digits most significant first, close it.
  task automatic push_literal(logic [31:0] val);
    opcode_t     digs[$];
    logic [31:0] v;
    v = val;
    while (v != 0) begin
      if (v % 7 == 0) digs.push_front(OP_H);
      else digs.push_front(opcode_t'(v % 7));
      v = v / 7;
    end
    issue(OP_N, 9'($urandom));
    foreach (digs[i]) issue(digs[i], 9'($urandom));
    issue(OP_E, 9'($urandom));
    sd++;
  endtask

  // Push a value the executor will see as 0..127, by literal or by input.
  task automatic push_small(logic [6:0] val);
    if ($urandom_range(0, 1)) push_literal(32'(val));
    else begin
      issue(OP_I, 9'(val));
      sd++;
    end
  endtask

  task automatic random_group();
    int k;
    k = $urandom_range(0, 9);
    if (sd > 40 && k < 3) k = 4;
    case (k)
      0: if (sd < 60) begin issue(OP_A, 9'($urandom)); sd++; end
      1: begin issue(OP_I, 9'($urandom)); sd++; end
      2: push_literal($urandom >> $urandom_range(1, 31));
      3: if (sd >= 2) begin issue(OP_S, 9'($urandom)); sd--; end
      4, 5: if (sd >= 2) begin issue(OP_T, 9'($urandom)); sd -= 2; end
      6: if (sd >= 1) begin
        // nonzero divisor on top
        if ($urandom_range(0, 1)) push_literal(($urandom >> $urandom_range(1, 31)) | 1);
        else begin issue(OP_I, 9'($urandom_range(1, 511))); sd++; end
        issue(OP_E, 9'($urandom));
      end
      7: begin push_small(7'($urandom)); issue(OP_O, 9'($urandom)); sd--; end
      8: if (sd >= 2) begin
        push_literal($urandom_range(1, sd - 1));
        issue(OP_H, 9'($urandom));
        sd--;
      end
      default: if (sd >= 1) begin
        k = $urandom_range(0, (sd - 1 > 256) ? 256 : sd - 1);
        if (k == 0) push_literal(0);
        else begin issue(OP_I, 9'(-k)); sd++; end
        issue(OP_H, 9'($urandom));
      end
    endcase
  endtask

  // Receiver: random stalls, one long hold-off, a stretch with no stalls.
  initial begin
    int rx_cyc;
    rx_cyc     = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (rx_cyc >= 600 && rx_cyc < 1000) out_tready <= 1'b0;
      else if (quiet()) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 99) >= 14);
    end
  end

  initial begin
    #30_000_000;
    $display("stack_language_executor test failed");
    $finish;
  end

  initial begin
    bit   filled;
    err_t last_err;
    filled    = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: line extremes, input extremes, largest literal, wrap cases.
    issue_at(OP_A, 16'h0000, 9'h000);
    issue_at(OP_A, 16'hFFFF, 9'h1FF);
    issue(OP_I, 9'h1FF);               // end of input
    issue(OP_I, 9'h0FF);
    issue(OP_I, 9'h100);               // most negative input value
    sd += 5;
    push_literal(32'h7FFF_FFFF);       // largest word that still fits
    issue(OP_I, 9'h1FF);
    issue(OP_S, 9'h000);               // wraps to the most negative word
    issue(OP_I, 9'h1FF);
    issue(OP_E, 9'h000);               // most negative over minus one
    sd += 1;
    issue(OP_I, 9'd127);
    issue(OP_O, 9'h000);
    issue(OP_T, 9'h000);
    sd -= 2;

    // Random well-formed groups, with one deep fill of the whole stack.
    while (nitems < 430) begin
      if (!filled && nitems > 40) begin
        filled = 1'b1;
        while (sd < 255) begin
          if ($urandom_range(0, 1)) issue(OP_A, 9'($urandom));
          else issue(OP_I, 9'($urandom));
          sd++;
        end
        push_literal(250);             // roll from near the bottom
        issue(OP_H, 9'h000);
        sd--;
        issue(OP_I, 9'(-200));
        issue(OP_H, 9'h000);           // duplicate deep, stack now full
        sd++;
        while (sd > 20) begin
          issue(OP_T, 9'($urandom));
          sd -= 2;
        end
      end
      random_group();
    end

    // Close with one error, then show the halt holds.
    last_err = err_t'($urandom_range(1, 6));
    case (last_err)
      ERR_UNDER: begin
        while (sd >= 2) begin issue(OP_T, 9'($urandom)); sd -= 2; end
        if (sd == 0) begin issue(OP_A, 9'($urandom)); sd++; end
        issue(OP_T, 9'($urandom));
      end
      ERR_ROLL: begin
        push_literal(sd + $urandom_range(0, 5));
        issue(OP_H, 9'($urandom));
      end
      ERR_ASCII: begin
        push_literal($urandom_range(128, 1000));
        issue(OP_O, 9'($urandom));
      end
      ERR_LIT: begin
        issue(OP_N, 9'($urandom));
        repeat (12) issue(OP_S, 9'($urandom));
        issue(OP_E, 9'($urandom));
      end
      ERR_DIV0: begin
        if (sd < 1) begin issue(OP_A, 9'($urandom)); sd++; end
        push_literal(0);
        issue(OP_E, 9'($urandom));
      end
      default: begin
        while (sd < DEPTH) begin issue(OP_A, 9'($urandom)); sd++; end
        issue(OP_A, 9'($urandom));
      end
    endcase
    repeat (6) issue(opcode_t'($urandom_range(0, 7)), 9'($urandom));
    in_tvalid <= 1'b0;

    // Drain: wait for every predicted result, then allow the longest walk.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fails == 0 && pending == 0) $display("stack_language_executor test passed");
    else $display("stack_language_executor test failed");
    $finish;
  end

endmodule
